// ----- hw/rtl/utf16_to_utf8_converter_defines.svh -----
// Assertion macros shared by the converter RTL files.
`ifndef UTF16_TO_UTF8_CONVERTER_DEFINES_SVH
`define UTF16_TO_UTF8_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define U16U8_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define U16U8_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/u16u8_pkg.sv -----
// Types, constants and the UTF-8 encode function of the converter.
package u16u8_pkg;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] LIM_1B    = 21'h80;
  localparam logic [20:0] LIM_2B    = 21'h800;
  localparam logic [20:0] LIM_3B    = 21'h10000;
  localparam logic [7:0]  LEAD_2B   = 8'hC0;
  localparam logic [7:0]  LEAD_3B   = 8'hE0;
  localparam logic [7:0]  LEAD_4B   = 8'hF0;
  localparam logic [7:0]  CONT_MARK = 8'h80;
  localparam logic [5:0]  CONT_MASK = 6'h3F;
  localparam int          MAX_BYTES = 6;

  typedef struct packed {
    logic [20:0] cp_a;
    logic [15:0] cp_b;
    logic        has_b;
    logic        fin;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } enc_t;

  function automatic enc_t u16u8_encode(input logic [20:0] cp);
    enc_t e;
    e.b   = '0;
    e.len = 3'd1;
    if (cp < LIM_1B) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < LIM_2B) begin
      e.b[0] = LEAD_2B | {3'd0, cp[10:6]};
      e.b[1] = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
      e.len  = 3'd2;
    end else if (cp < LIM_3B) begin
      e.b[0] = LEAD_3B | {4'd0, cp[15:12]};
      e.b[1] = CONT_MARK | {2'd0, cp[11:6] & CONT_MASK};
      e.b[2] = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
      e.len  = 3'd3;
    end else begin
      e.b[0] = LEAD_4B | {5'd0, cp[20:18]};
      e.b[1] = CONT_MARK | {2'd0, cp[17:12] & CONT_MASK};
      e.b[2] = CONT_MARK | {2'd0, cp[11:6] & CONT_MASK};
      e.b[3] = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

// ----- hw/rtl/u16u8_fifo.sv -----
// Short job queue between the classifying front and the byte-emitting back.
`include "utf16_to_utf8_converter_defines.svh"
module u16u8_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u16u8_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output u16u8_pkg::job_t  pop_job,
  output logic             not_empty
);
  import u16u8_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push_ok, pop_ok;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign push_ok   = push && !full;
  assign pop_ok    = pop && not_empty;
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `U16U8_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))

endmodule

// ----- hw/rtl/u16u8_front.sv -----
// Front part: accepts code units, pairs surrogates and queues encode jobs.
`include "utf16_to_utf8_converter_defines.svh"
module u16u8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      in_code_unit,
  input  logic             in_final_unit,
  output logic             q_push,
  output u16u8_pkg::job_t  q_job,
  input  logic             q_full
);
  import u16u8_pkg::*;

  logic [15:0] held_high_r, held_high_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        accept, is_high, is_low, hold_now;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_high  = (in_code_unit >= HIGH_MIN) && (in_code_unit <= HIGH_MAX);
  assign is_low   = (in_code_unit >= LOW_MIN) && (in_code_unit <= LOW_MAX);
  assign hold_now = is_high && !in_final_unit && !(held_valid_r && is_low);

  always_comb begin
    held_high_nxt  = held_high_r;
    held_valid_nxt = held_valid_r;
    q_push         = 1'b0;
    q_job.fin      = in_final_unit;
    q_job.cp_b     = in_code_unit;
    q_job.has_b    = 1'b0;
    q_job.cp_a     = {5'd0, in_code_unit};
    if (held_valid_r && is_low) begin
      q_job.cp_a = SUPP_BASE + {1'b0, held_high_r[9:0], in_code_unit[9:0]};
    end else if (held_valid_r) begin
      q_job.cp_a  = {5'd0, held_high_r};
      q_job.has_b = !hold_now;
    end
    if (accept) begin
      q_push         = held_valid_r || !hold_now;
      held_valid_nxt = hold_now;
      held_high_nxt  = hold_now ? in_code_unit : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_high_r  <= 16'd0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_high_r  <= held_high_nxt;
    end
  end

  `U16U8_ASSERT_NEXT(a_fin_clears_hold, clk, rst_n, accept && in_final_unit, !held_valid_r)

endmodule

// ----- hw/rtl/u16u8_back.sv -----
// Back part: expands queued jobs into UTF-8 bytes, one beat per cycle while out_stall is low.
`include "utf16_to_utf8_converter_defines.svh"
module u16u8_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  u16u8_pkg::job_t  q_job,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_string_end
);
  import u16u8_pkg::*;

  logic [7:0] bytes_r [MAX_BYTES];
  logic [7:0] bytes_nxt [MAX_BYTES];
  logic [2:0] nbytes_r, nbytes_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       fin_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_run_last_r, out_string_end_r;
  logic       slot_free, issue, last, load;
  enc_t       enc_a, enc_b;
  logic [2:0] pos, k;

  assign slot_free = !out_valid_r || !out_stall;
  assign issue     = busy_r && slot_free;
  assign last      = (idx_r == nbytes_r - 3'd1);
  assign load      = q_not_empty && (!busy_r || (issue && last));
  assign q_pop     = load;

  always_comb begin
    enc_a = u16u8_encode(q_job.cp_a);
    enc_b = u16u8_encode({5'd0, q_job.cp_b});
    nbytes_nxt = enc_a.len + (q_job.has_b ? enc_b.len : 3'd0);
    pos = 3'd0;
    k   = 3'd0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      pos = 3'(i);
      k   = pos - enc_a.len;
      bytes_nxt[i] = (pos < enc_a.len) ? enc_a.b[pos[1:0]] : enc_b.b[k[1:0]];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = issue;
    end
    if (issue) begin
      idx_nxt = idx_r + 3'd1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r  <= bytes_nxt;
      nbytes_r <= nbytes_nxt;
      fin_r    <= q_job.fin;
    end
    if (issue) begin
      out_byte_r       <= bytes_r[idx_r];
      out_run_last_r   <= last;
      out_string_end_r <= last && fin_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_string_end = out_string_end_r;

  `U16U8_ASSERT_IMPLY(a_end_is_last, clk, rst_n, out_valid_r && out_string_end_r, out_run_last_r)
  `U16U8_ASSERT_IMPLY(a_idx_in_range, clk, rst_n, busy_r, idx_r < nbytes_r)

endmodule

// ----- hw/rtl/utf16_to_utf8_converter.sv -----
// A unit's first byte is registered in the queue, the byte buffer and out_byte.
// Throughput: one output beat per cycle while out_stall is low; a unit yields
// 0 to 6 bytes, through the single-byte output register of the back part.
// A held high surrogate takes one input beat and no output beat.
// Reset (synchronous, rst_n low) drops any held surrogate, empties the queue and
// clears the output valid.
module utf16_to_utf8_converter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_final_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_string_end
);
  import u16u8_pkg::*;

  logic q_push, q_full, q_pop, q_not_empty;
  job_t push_job, pop_job;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_unit  (in_code_unit),
    .in_final_unit (in_final_unit),
    .q_push        (q_push),
    .q_job         (push_job),
    .q_full        (q_full)
  );

  u16u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_job          (pop_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule
